### hdl/tap_tempo_estimator_assert.svh
// ---------------------------------------------------------------------------
// Tap tempo estimator assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define TTE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tap_tempo_estimator: same-cycle check failed");

// next-cycle implication
`define TTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tap_tempo_estimator: next-cycle check failed");

`endif

### hdl/tte_pkg.sv
// ---------------------------------------------------------------------------
// tte_pkg
// Constants, widths and inter-module structs of the tap tempo estimator.
// ---------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int NUM_TAPS    = 4;
  localparam int STAMP_BITS  = 32;
  localparam int TICK_RATE_W = 20;
  localparam int GAP_W       = 32;
  localparam int TEMPO_W     = 24;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam int SLOT_IDX_W  = $clog2(NUM_TAPS);
  localparam int GAP_CNT_W   = $clog2(NUM_TAPS);
  localparam int SUM_W       = STAMP_BITS + $clog2(NUM_TAPS);
  localparam int BPM_SCALE_W = 14;
  localparam int SCALED_W    = BPM_SCALE_W + TICK_RATE_W;
  localparam int NUM_W       = SCALED_W + GAP_CNT_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  // 60 s/min * 256 (Q.8)
  localparam logic [BPM_SCALE_W-1:0] BPM_SCALE = 14'd15360;
  localparam logic [TEMPO_W-1:0]     TEMPO_MAX = {TEMPO_W{1'b1}};

  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST   = 20'd1000;
  localparam logic [GAP_W-1:0]       RESTART_GAP_RST = 32'd2000;

  // register index = paddr[2]
  localparam logic REG_TICK_RATE   = 1'b0;
  localparam logic REG_RESTART_GAP = 1'b1;

  typedef struct packed {
    logic load_tap;
    logic check_step;
    logic update;
    logic gap_step;
    logic scale;
    logic div_load;
    logic div_step;
    logic emit;
  } tte_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_last;
  } tte_status_t;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo;
    logic               restarted;
    logic               tempo_valid;
  } tte_result_t;

endpackage

`default_nettype wire

### hdl/tap_tempo_estimator.sv
// ---------------------------------------------------------------------------
// tap_tempo_estimator
// Tempo in Q.8 BPM from the spacing of the last few tap timestamps.
// ---------------------------------------------------------------------------
//
//   channel   handshake                   payload
//   -------   -------------------------   ------------------------------------
//   tap       tap_valid / tap_ready       tap_time
//   result    result_valid / result_ready tempo_bpm_q8, restarted, tempo_valid
//   config    APB psel/penable/pready     paddr, pwdata, prdata
//
// One tap per transaction; the 36-step restoring divider is the longest part
// of the work, and a tap whose gaps are all zero skips it.
// Work on one tap at a time; the next tap is taken once the previous result
// has moved into the output register, which may still wait for result_ready.
// A stalled output holds the sequencer in its last step, never losing data.
// Synchronous active-high reset clears the slot valid bits, sequencer and
// output valid, and loads tick_rate = 1000, restart_gap = 2000.
//
`default_nettype none

`include "tap_tempo_estimator_assert.svh"

module tap_tempo_estimator (
  input  wire                                 clk,
  input  wire                                 rst,
  // tap channel
  input  wire                                 tap_valid,
  output logic                                tap_ready,
  input  wire [31:0]                          tap_time,
  // result channel
  output logic                                result_valid,
  input  wire                                 result_ready,
  output logic [23:0]                         tempo_bpm_q8,
  output logic                                restarted,
  output logic                                tempo_valid,
  // configuration
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [tte_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire [tte_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [tte_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import tte_pkg::*;

  logic [TICK_RATE_W-1:0] tick_rate;
  logic [GAP_W-1:0]       restart_gap;
  logic                   cfg_write;
  logic                   reg_sel;

  tte_cmd_t    cmd;
  tte_status_t status;
  tte_result_t result;
  logic        out_free;

  // ---- configuration registers --------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate   <= TICK_RATE_RST;
      restart_gap <= RESTART_GAP_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TICK_RATE:   tick_rate   <= pwdata[TICK_RATE_W-1:0];
        REG_RESTART_GAP: restart_gap <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TICK_RATE:   prdata = APB_DATA_W'(tick_rate);
      REG_RESTART_GAP: prdata = APB_DATA_W'(restart_gap);
      default:         prdata = '0;
    endcase
  end

  // ---- sequencer and datapath ---------------------------------------------
  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .out_free  (out_free),
    .status    (status),
    .cmd       (cmd)
  );

  // stamps wider than the port are zero-extended, narrower ones keep the low bits
  tte_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .tap_time    (STAMP_BITS'(tap_time)),
    .tick_rate   (tick_rate),
    .restart_gap (restart_gap),
    .status      (status),
    .result      (result)
  );

  // ---- output register: frees the sequencer from result_ready -------------
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tempo_bpm_q8 <= result.tempo;
      restarted    <= result.restarted;
      tempo_valid  <= result.tempo_valid;
    end
  end

  // ---- checks -------------------------------------------------------------
  // a taken tap keeps the input closed while it is being worked on
  `TTE_ASSERT_NEXT(a_busy_after_tap, clk, rst, tap_valid && tap_ready, !tap_ready)
  // a new result only lands in a free output register
  `TTE_ASSERT_NOW(a_emit_into_free, clk, rst, cmd.emit, !result_valid || result_ready)
  // no counted gap means no tempo
  `TTE_ASSERT_NOW(a_zero_without_gap, clk, rst, result_valid && !tempo_valid, tempo_bpm_q8 == '0)

endmodule

`default_nettype wire

### hdl/tte_ctrl.sv
// ---------------------------------------------------------------------------
// tte_ctrl
// Sequencer: slot check, history update, gap scan, scale, divide, hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tte_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  tap_valid,
  output logic                 tap_ready,
  input  wire                  out_free,
  input  tte_pkg::tte_status_t status,
  output tte_pkg::tte_cmd_t    cmd
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    IDLE, CHECK, UPDATE, GAPS, SCALE, DIV_LOAD, DIV, FINISH
  } state_t;

  localparam logic [SLOT_IDX_W-1:0] CHECK_LAST = SLOT_IDX_W'(NUM_TAPS - 1);
  localparam logic [SLOT_IDX_W-1:0] GAPS_LAST  = SLOT_IDX_W'(NUM_TAPS - 2);

  state_t                state;
  logic [SLOT_IDX_W-1:0] step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          step_cnt <= '0;
          if (tap_valid) state <= CHECK;
        end
        CHECK: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == CHECK_LAST) state <= UPDATE;
        end
        UPDATE: begin
          step_cnt <= '0;
          state    <= GAPS;
        end
        GAPS: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == GAPS_LAST) state <= SCALE;
        end
        SCALE:    state <= DIV_LOAD;
        DIV_LOAD: state <= status.count_zero ? FINISH : DIV;
        DIV:      if (status.div_last) state <= FINISH;
        FINISH:   if (out_free) state <= IDLE;
        default:  state <= IDLE;
      endcase
    end
  end

  assign tap_ready = (state == IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_tap   = (state == IDLE) && tap_valid;
    cmd.check_step = (state == CHECK);
    cmd.update     = (state == UPDATE);
    cmd.gap_step   = (state == GAPS);
    cmd.scale      = (state == SCALE);
    cmd.div_load   = (state == DIV_LOAD);
    cmd.div_step   = (state == DIV);
    cmd.emit       = (state == FINISH) && out_free;
  end

endmodule

`default_nettype wire

### hdl/tte_datapath.sv
// ---------------------------------------------------------------------------
// tte_datapath
// Stamp history, slot scan, gap accumulator and restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module tte_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  tte_pkg::tte_cmd_t                   cmd,
  input  wire [tte_pkg::STAMP_BITS-1:0]       tap_time,
  input  wire [tte_pkg::TICK_RATE_W-1:0]      tick_rate,
  input  wire [tte_pkg::GAP_W-1:0]            restart_gap,
  output tte_pkg::tte_status_t                status,
  output tte_pkg::tte_result_t                result
);
  import tte_pkg::*;

  function automatic logic [STAMP_BITS-1:0] abs_diff(
    input logic [STAMP_BITS-1:0] a,
    input logic [STAMP_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [STAMP_BITS-1:0] tap;
  logic                  restart;
  logic [STAMP_BITS-1:0] stamps      [NUM_TAPS];
  logic                  slot_valid  [NUM_TAPS];
  logic [STAMP_BITS-1:0] stamps_next [NUM_TAPS];
  logic                  valid_next  [NUM_TAPS];
  // scan line: walked through slot 0 one entry per step
  logic [STAMP_BITS-1:0] scan        [NUM_TAPS];
  logic                  scan_valid  [NUM_TAPS];

  logic [SUM_W-1:0]      sum;
  logic [GAP_CNT_W-1:0]  count;
  logic [SCALED_W-1:0]   scaled;
  logic [SUM_W:0]        rem;
  logic [NUM_W-1:0]      quo;
  logic [DIV_CNT_W-1:0]  div_cnt;

  logic [STAMP_BITS-1:0] chk_diff;
  logic [STAMP_BITS-1:0] gap;
  logic [SUM_W:0]        rem_shift;
  logic [SUM_W:0]        divisor;

  assign chk_diff  = abs_diff(scan[0], tap);
  assign gap       = abs_diff(scan[0], scan[1]);
  assign rem_shift = {rem[SUM_W-1:0], quo[NUM_W-1]};
  assign divisor   = {1'b0, sum};

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (restart || i == 0) begin
        stamps_next[i] = tap;
        valid_next[i]  = 1'b1;
      end else begin
        stamps_next[i] = stamps[i-1];
        valid_next[i]  = slot_valid[i-1];
      end
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) slot_valid[i] <= 1'b0;
    end else if (cmd.update) begin
      for (int i = 0; i < NUM_TAPS; i++) slot_valid[i] <= valid_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tap) begin
      tap     <= tap_time;
      restart <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        scan[i]       <= stamps[i];
        scan_valid[i] <= slot_valid[i];
      end
    end

    if (cmd.check_step) begin
      // both sides widened so no stamp width loses bits in the compare
      if (!scan_valid[0] ||
          {{GAP_W{1'b0}}, chk_diff} > {{STAMP_BITS{1'b0}}, restart_gap}) restart <= 1'b1;
      for (int i = 0; i < NUM_TAPS - 1; i++) begin
        scan[i]       <= scan[i+1];
        scan_valid[i] <= scan_valid[i+1];
      end
    end

    if (cmd.update) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        stamps[i] <= stamps_next[i];
        scan[i]   <= stamps_next[i];
      end
      sum   <= '0;
      count <= '0;
    end

    if (cmd.gap_step) begin
      if (gap != '0) begin
        sum   <= sum + SUM_W'(gap);
        count <= count + 1'b1;
      end
      for (int i = 0; i < NUM_TAPS - 1; i++) scan[i] <= scan[i+1];
    end

    if (cmd.scale) scaled <= SCALED_W'(tick_rate) * SCALED_W'(BPM_SCALE);

    if (cmd.div_load) begin
      rem     <= '0;
      quo     <= NUM_W'(scaled) * NUM_W'(count);
      div_cnt <= '0;
    end

    // restoring division, one quotient bit per step
    if (cmd.div_step) begin
      if (rem_shift >= divisor) begin
        rem <= rem_shift - divisor;
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.count_zero = (count == '0);
  assign status.div_last   = (div_cnt == DIV_CNT_W'(NUM_W - 1));

  always_comb begin
    if (count == '0) begin
      result.tempo = '0;
    end else if (|quo[NUM_W-1:TEMPO_W]) begin
      result.tempo = TEMPO_MAX;
    end else begin
      result.tempo = quo[TEMPO_W-1:0];
    end
    result.restarted   = restart;
    result.tempo_valid = (count != '0);
  end

endmodule

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb: tap tempo estimator testbench
// Feeds tap timestamps through the valid/ready tap channel, predicts tempo,
// restart and valid flags per tap, and checks every result transaction.
// Runs directed corner taps, then random tap runs under several register
// settings, with random idle cycles on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tte_pkg::*;

  localparam int STALL_LIMIT  = 5000;   // cycles with no transaction at all
  localparam int TAIL_CYCLES  = 200;    // settle time after the last result
  localparam int RANDOM_TAPS  = 135;    // per register setting

  localparam logic [APB_ADDR_W-1:0] ADDR_TICK_RATE   = {REG_TICK_RATE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_RESTART_GAP = {REG_RESTART_GAP, 2'b00};

  localparam logic [31:0] TICK_RATE_MASK   = {{(32-TICK_RATE_W){1'b0}}, {TICK_RATE_W{1'b1}}};
  localparam logic [31:0] RESTART_GAP_MASK = 32'hFFFF_FFFF;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  tap_valid = 1'b0;
  logic                  tap_ready;
  logic [31:0]           tap_time = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [TEMPO_W-1:0]    tempo_bpm_q8;
  logic                  restarted;
  logic                  tempo_valid;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tap_tempo_estimator dut (
    .clk          (clk),
    .rst          (rst),
    .tap_valid    (tap_valid),
    .tap_ready    (tap_ready),
    .tap_time     (tap_time),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tempo_bpm_q8 (tempo_bpm_q8),
    .restarted    (restarted),
    .tempo_valid  (tempo_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Tempo predictor: shadow copy of the tap history and both registers.
  // -------------------------------------------------------------------------
  logic [STAMP_BITS-1:0]  hist_stamp [NUM_TAPS];
  logic                   hist_ok    [NUM_TAPS];
  logic [TICK_RATE_W-1:0] cur_tick_rate   = TICK_RATE_RST;
  logic [GAP_W-1:0]       cur_restart_gap = RESTART_GAP_RST;

  tte_result_t            tempo_expect [$];   // predicted results, oldest first
  logic [31:0]            tap_queue    [$];   // taps not yet driven

  int errors         = 0;
  int taps_queued    = 0;
  int taps_accepted  = 0;
  int results_seen   = 0;
  int restarts_seen  = 0;
  int saturated_seen = 0;
  int settings_run   = 0;
  int cycle_no       = 0;
  int stall_cycles   = 0;
  logic tap_taken    = 1'b0;

  initial begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      hist_stamp[i] = '0;
      hist_ok[i]    = 1'b0;
    end
  end

  function automatic logic [STAMP_BITS-1:0] stamp_dist(logic [STAMP_BITS-1:0] a,
                                                      logic [STAMP_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Update the history with one tap and return the tempo it yields.
  function automatic tte_result_t predict_tempo(logic [31:0] stamp_in);
    tte_result_t           r;
    logic [STAMP_BITS-1:0] stamp;
    logic                  reload;
    logic [63:0]           gap_sum;
    logic [63:0]           gap_cnt;
    logic [63:0]           numer;
    logic [63:0]           quot;
    logic [STAMP_BITS-1:0] d;
    stamp   = stamp_in[STAMP_BITS-1:0];
    reload  = 1'b0;
    gap_sum = '0;
    gap_cnt = '0;
    // any empty slot or any stamp too far away restarts the history
    for (int i = 0; i < NUM_TAPS; i++)
      if (!hist_ok[i] || stamp_dist(hist_stamp[i], stamp) > cur_restart_gap)
        reload = 1'b1;
    if (reload) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        hist_stamp[i] = stamp;
        hist_ok[i]    = 1'b1;
      end
    end else begin
      for (int i = NUM_TAPS - 1; i > 0; i--) begin
        hist_stamp[i] = hist_stamp[i-1];
        hist_ok[i]    = hist_ok[i-1];
      end
      hist_stamp[0] = stamp;
      hist_ok[0]    = 1'b1;
    end
    // only nonzero neighbour gaps take part in the average
    for (int i = 1; i < NUM_TAPS; i++) begin
      d = stamp_dist(hist_stamp[i], hist_stamp[i-1]);
      if (d != 0) begin
        gap_sum += 64'(d);
        gap_cnt += 1;
      end
    end
    r.tempo = '0;
    if (gap_cnt != 0) begin
      numer = 64'(BPM_SCALE) * 64'(cur_tick_rate) * gap_cnt;
      quot  = numer / gap_sum;
      r.tempo = (quot > 64'(TEMPO_MAX)) ? TEMPO_MAX : quot[TEMPO_W-1:0];
    end
    r.restarted   = reload;
    r.tempo_valid = (gap_cnt != 0);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: samples both channels and the config port at the rising edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    tte_result_t want;
    logic        active;
    active    = 1'b0;
    tap_taken = 1'b0;
    if (!rst) begin
      cycle_no++;
      if (psel && penable && pready) begin
        active = 1'b1;
        if (pwrite) begin
          case (paddr)
            ADDR_TICK_RATE:   cur_tick_rate   = pwdata[TICK_RATE_W-1:0];
            ADDR_RESTART_GAP: cur_restart_gap = pwdata[GAP_W-1:0];
            default: ;
          endcase
        end
      end
      if (tap_valid && tap_ready) begin
        active    = 1'b1;
        tap_taken = 1'b1;
        want      = predict_tempo(tap_time);
        tempo_expect.push_back(want);
        taps_accepted++;
        if (want.restarted) restarts_seen++;
        if (want.tempo == TEMPO_MAX) saturated_seen++;
      end
      if (result_valid && result_ready) begin
        active = 1'b1;
        results_seen++;
        if (tempo_expect.size() == 0) begin
          $error("result transaction with no tap waiting: tempo_bpm_q8=%0d", tempo_bpm_q8);
          errors++;
        end else begin
          want = tempo_expect.pop_front();
          if (tempo_bpm_q8 !== want.tempo) begin
            $error("tempo_bpm_q8 mismatch: expected %0d, actual %0d", want.tempo,
                   tempo_bpm_q8);
            errors++;
          end
          if (restarted !== want.restarted) begin
            $error("restarted mismatch: expected %0b, actual %0b", want.restarted, restarted);
            errors++;
          end
          if (tempo_valid !== want.tempo_valid) begin
            $error("tempo_valid mismatch: expected %0b, actual %0b", want.tempo_valid,
                   tempo_valid);
            errors++;
          end
        end
      end
      // watchdog: a hung handshake ends the run
      stall_cycles = active ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Random idling, except in a calm window that recurs through the run.
  function automatic logic idle_now();
    if ((cycle_no % 3000) < 600) return 1'b0;
    return ($urandom_range(99) < 16);
  endfunction

  // -------------------------------------------------------------------------
  // Drivers: tap source and result sink, both updated at the falling edge.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (tap_valid && !tap_taken) begin
      // hold the transaction until the block takes it
    end else if (tap_queue.size() != 0 && !idle_now()) begin
      tap_valid <= 1'b1;
      tap_time  <= tap_queue.pop_front();
    end else begin
      tap_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    result_ready <= !rst && !idle_now();
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic push_tap(input logic [31:0] t);
    tap_queue.push_back(t);
    taps_queued++;
  endtask

  // APB write, then read back the same register.
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value,
                           input logic [31:0] mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask)) begin
      $error("register readback mismatch at 0x%0h: expected 0x%0h, actual 0x%0h", addr,
             value & mask, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] rate, input logic [31:0] gap);
    reg_write(ADDR_TICK_RATE, rate, TICK_RATE_MASK);
    reg_write(ADDR_RESTART_GAP, gap, RESTART_GAP_MASK);
  endtask

  // Mostly well-formed tap runs inside the restart gap, plus repeats,
  // tiny spacings, backward steps, jumps past the gap and pure noise.
  task automatic queue_random_taps(input int n, input logic [31:0] gap);
    logic [31:0] t;
    logic [31:0] span;
    int          roll;
    t    = $urandom;
    span = (gap < 3) ? gap : gap / 3;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 5)       t = $urandom;
      else if (roll < 12) t = t;
      else if (roll < 18) t = t + gap + 32'($urandom_range(1, 1000));
      else if (roll < 30) t = t + 32'($urandom_range(1, 3));
      else if (roll < 38) t = t - 32'($urandom_range(0, span));
      else                t = t + 32'($urandom_range(0, span));
      push_tap(t);
    end
  endtask

  task automatic wait_drained();
    while (taps_accepted != taps_queued || tempo_expect.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input logic [31:0] gap);
    queue_random_taps(RANDOM_TAPS, gap);
    wait_drained();
    settings_run++;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: 1000 ticks/s, 2000 tick restart gap
    push_tap(32'd0);           // empty history, tap at time zero
    push_tap(32'd500);
    push_tap(32'd1000);
    push_tap(32'd1500);        // steady 120 BPM
    push_tap(32'd1500);        // repeated stamp, zero gap skipped
    push_tap(32'd1000);        // backward step, absolute distance
    push_tap(32'd5000);        // beyond the gap: restart
    push_tap(32'd5000);        // all gaps zero: no tempo
    push_tap(32'hFFFF_FFFF);
    push_tap(32'hFFFF_FFFE);
    push_tap(32'hFFFF_FFFD);
    push_tap(32'hFFFF_FFFC);
    push_tap(32'd0);           // no wraparound: restart
    push_tap(32'd2000);        // exactly at the gap keeps history
    push_tap(32'd4001);        // one past the gap from the newest slot
    run_random(32'd2000);

    // 1 MHz tick clock, tiny spacing: saturated tempo
    set_regs(32'd1_000_000, 32'd2000);
    push_tap(32'd100);
    push_tap(32'd101);
    push_tap(32'd102);
    push_tap(32'd103);
    push_tap(32'd104);
    run_random(32'd2000);

    // zero tick rate, widest restart gap
    set_regs(32'd0, 32'hFFFF_FFFF);
    push_tap(32'd10);
    push_tap(32'd20);
    push_tap(32'd30);
    run_random(32'hFFFF_FFFF);

    // full-scale tick rate, zero gap: any change restarts
    set_regs(32'hFFFFF, 32'd0);
    push_tap(32'd7);
    push_tap(32'd7);
    push_tap(32'd7);
    push_tap(32'd8);
    run_random(32'd0);

    set_regs(32'd1, 32'd1);
    run_random(32'd1);

    set_regs(32'd48000, 32'd96000);
    run_random(32'd96000);

    // slowest scaling with unlimited gap: tiny tempos
    set_regs(32'd1, 32'hFFFF_FFFF);
    run_random(32'hFFFF_FFFF);

    set_regs(32'(TICK_RATE_RST), 32'(RESTART_GAP_RST));
    run_random(32'(RESTART_GAP_RST));

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (tempo_expect.size() != 0) begin
      $error("%0d predicted results never arrived", tempo_expect.size());
      errors++;
    end
    $display("Ran %0d taps over %0d register settings; %0d results checked.",
             taps_accepted, settings_run, results_seen);
    $display("History restarts: %0d, saturated tempos: %0d.", restarts_seen,
             saturated_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
